// ----- rtl/core/plf_pkg.sv -----
// package for the palette fade unit: constants, types and codes
`timescale 1ns / 1ps
package plf_pkg;
  localparam int PaletteEntries = 256;
  localparam int ColorWidth = 24;
  localparam logic [7:0] OpaqueAlpha = 8'hFF;
  localparam logic [7:0] RangeStartReset = 8'd0;
  localparam logic [7:0] RangeEndReset = 8'd255;
  localparam logic [7:0] FadeStepsReset = 8'd30;

  typedef enum logic [1:0] {
    KIND_WR_SOURCE = 2'd0,
    KIND_WR_TARGET = 2'd1,
    KIND_SET_FRAME = 2'd2,
    KIND_LOOKUP    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    CFG_RANGE_START = 2'd0,
    CFG_RANGE_END   = 2'd1,
    CFG_FADE_STEPS  = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DIVIDE,
    ST_OUTPUT
  } state_t;

  // control handed from sequencer to blend unit
  typedef struct packed {
    logic       start;
    logic       fade;
    logic [7:0] frame;
    logic [7:0] steps;
  } blend_ctrl_t;
endpackage

// ----- rtl/core/plf_ram.sv -----
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
module plf_ram #(
  parameter int Width = 24,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

// ----- rtl/core/plf_blend.sv -----
// blend unit: three channels, each with its own restoring divider, one quotient bit a cycle
`timescale 1ns / 1ps
module plf_blend (
  input  logic                 clk,
  input  logic                 rst,
  input  plf_pkg::blend_ctrl_t ctrl,
  input  logic [23:0]          src,
  input  logic [23:0]          tgt,
  output logic                 done,
  output logic [23:0]          color
);
  import plf_pkg::*;

  // |delta| * frame fits 16 bits; divided by steps, quotient 16 bits
  logic [15:0] num [3];
  logic [15:0] quo [3];
  logic [8:0]  rem [3];
  logic [2:0]  neg;
  logic [7:0]  base [3];
  logic [7:0]  steps;
  logic        fade;
  logic [4:0]  count;
  logic        busy;
  logic [8:0]  trial [3];
  logic [23:0] mixed;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      trial[c] = {rem[c][7:0], num[c][15]};
    end
    for (int c = 0; c < 3; c++) begin
      if (neg[c]) begin
        mixed[c*8 +: 8] = base[c] - quo[c][7:0];
      end else begin
        mixed[c*8 +: 8] = base[c] + quo[c][7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
        count <= 5'd16;
      end else if (busy) begin
        count <= count - 5'd1;
        if (count == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      steps <= ctrl.steps;
      fade <= ctrl.fade;
      for (int c = 0; c < 3; c++) begin
        logic [7:0] s;
        logic [7:0] t;
        logic [7:0] mag;
        s = src[c*8 +: 8];
        t = tgt[c*8 +: 8];
        mag = (t >= s) ? t - s : s - t;
        neg[c] <= (t < s);
        base[c] <= s;
        num[c] <= mag * ctrl.frame;
        rem[c] <= '0;
        quo[c] <= '0;
      end
    end else if (busy) begin
      for (int c = 0; c < 3; c++) begin
        num[c] <= {num[c][14:0], 1'b0};
        if (trial[c] >= {1'b0, steps}) begin
          rem[c] <= trial[c] - {1'b0, steps};
          quo[c] <= {quo[c][14:0], 1'b1};
        end else begin
          rem[c] <= trial[c];
          quo[c] <= {quo[c][14:0], 1'b0};
        end
      end
    end
  end

  assign color = fade ? mixed : {base[2], base[1], base[0]};

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("blend done while still busy");
  a_start_idle: assert property (@(posedge clk) disable iff (rst) ctrl.start |-> !busy)
    else $error("blend restarted while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held longer than one cycle");
endmodule

// ----- rtl/core/plf_seq.sv -----
// sequencer: accepts beats, tracks the frame, runs lookups through the blend unit
`timescale 1ns / 1ps
module plf_seq #(
  parameter int PaletteEntries = plf_pkg::PaletteEntries
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           kind,
  input  logic [7:0]           entry_index,
  input  logic [7:0]           fade_frame,
  input  logic [7:0]           range_start,
  input  logic [7:0]           range_end,
  input  logic [7:0]           fade_steps,
  input  logic                 blend_done,
  output plf_pkg::blend_ctrl_t ctrl,
  output logic                 lookup_read,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_black
);
  import plf_pkg::*;

  state_t     state;
  state_t     state_next;
  logic [7:0] frame;
  logic [7:0] idx;
  logic       accept;
  logic       in_range;

  assign accept = in_valid && !in_stall;
  assign in_range = {24'd0, idx} < PaletteEntries;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && kind_t'(kind) == KIND_LOOKUP) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = in_range ? ST_DIVIDE : ST_OUTPUT;
      end
      ST_DIVIDE: begin
        if (blend_done) begin
          state_next = ST_OUTPUT;
        end
      end
      ST_OUTPUT: begin
        if (!out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state != ST_IDLE);
    out_valid = (state == ST_OUTPUT);
    lookup_read = (state == ST_READ);
    ctrl.start = (state == ST_READ) && in_range;
    ctrl.steps = fade_steps;
    ctrl.frame = (frame > fade_steps) ? fade_steps : frame;
    ctrl.fade = (fade_steps != 8'd0) && (idx >= range_start) && (idx <= range_end);
    out_black = !in_range;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      frame <= '0;
    end else begin
      state <= state_next;
      if (accept && kind_t'(kind) == KIND_SET_FRAME) begin
        frame <= fade_frame;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      idx <= entry_index;
    end
  end

  a_no_out_idle: assert property (@(posedge clk) disable iff (rst)
      (state == ST_IDLE) |-> !out_valid)
    else $error("result shown while idle");
  a_hold_out: assert property (@(posedge clk) disable iff (rst)
      (out_valid && out_stall) |=> out_valid)
    else $error("stalled result dropped");
  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
      ctrl.start |-> in_stall)
    else $error("input open during lookup");
endmodule

// ----- rtl/core/palette_lookup_with_fade.sv -----
// top level of the palette lookup unit with linear fade
// order: a write or frame beat takes effect on its accepting edge; a lookup goes through
//   the read state, divider load, bit-serial divide and output state before its result shows
// input: one lookup at a time, the input stalling until its result is taken; writes and
//   frame updates are taken every cycle while no lookup is in flight
// reset: rst synchronous, clears frame, presets registers; palettes undefined until written
`timescale 1ns / 1ps
module palette_lookup_with_fade #(
  parameter int PaletteEntries = plf_pkg::PaletteEntries
) (
  input  logic        clk,
  input  logic        rst,
  // item channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [7:0]  entry_index,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  logic [7:0]  fade_frame,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] rgba,
  // register write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import plf_pkg::*;

  localparam int AddrWidth = $clog2(PaletteEntries);

  logic [7:0]  range_start;
  logic [7:0]  range_end;
  logic [7:0]  fade_steps;
  logic        accept;
  logic        in_palette;
  logic        wr_src;
  logic        wr_tgt;
  logic [23:0] wr_color;
  logic [23:0] src_q;
  logic [23:0] tgt_q;
  logic [23:0] blend_color;
  logic        blend_done;
  logic        lookup_read;
  logic        out_black;
  blend_ctrl_t ctrl;
  logic [AddrWidth-1:0] addr;

  // register port is always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_start <= RangeStartReset;
      range_end <= RangeEndReset;
      fade_steps <= FadeStepsReset;
    end else if (cfg_valid) begin
      case (cfg_index_t'(cfg_index))
        CFG_RANGE_START: range_start <= cfg_data;
        CFG_RANGE_END:   range_end <= cfg_data;
        CFG_FADE_STEPS:  fade_steps <= cfg_data;
        default: ;
      endcase
    end
  end

  // palette writes; indexes beyond the palette are dropped
  assign accept = in_valid && !in_stall;
  assign in_palette = {24'd0, entry_index} < PaletteEntries;
  assign addr = entry_index[AddrWidth-1:0];
  assign wr_src = accept && in_palette && kind_t'(kind) == KIND_WR_SOURCE;
  assign wr_tgt = accept && in_palette && kind_t'(kind) == KIND_WR_TARGET;
  assign wr_color = {blue, green, red};

  // palettes read at the beat's index on the accepting edge; data ready in the read state
  plf_ram #(.Width(ColorWidth), .Depth(PaletteEntries)) u_src (
    .clk(clk), .wr_en(wr_src), .wr_addr(addr), .wr_data(wr_color),
    .rd_addr(addr), .rd_data(src_q)
  );

  plf_ram #(.Width(ColorWidth), .Depth(PaletteEntries)) u_tgt (
    .clk(clk), .wr_en(wr_tgt), .wr_addr(addr), .wr_data(wr_color),
    .rd_addr(addr), .rd_data(tgt_q)
  );

  plf_seq #(.PaletteEntries(PaletteEntries)) u_seq (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .entry_index(entry_index), .fade_frame(fade_frame),
    .range_start(range_start), .range_end(range_end), .fade_steps(fade_steps),
    .blend_done(blend_done), .ctrl(ctrl), .lookup_read(lookup_read),
    .out_valid(out_valid), .out_stall(out_stall), .out_black(out_black)
  );

  plf_blend u_blend (
    .clk(clk), .rst(rst), .ctrl(ctrl), .src(src_q), .tgt(tgt_q),
    .done(blend_done), .color(blend_color)
  );

  // pack as opaque rgba; black for an index beyond the palette
  assign rgba = {OpaqueAlpha, out_black ? 24'd0 : blend_color};

  a_no_write_busy: assert property (@(posedge clk) disable iff (rst)
      lookup_read |-> !(wr_src || wr_tgt))
    else $error("palette written during a lookup");
  a_out_one_lookup: assert property (@(posedge clk) disable iff (rst)
      out_valid |-> in_stall)
    else $error("input open while result pending");
  a_alpha: assert property (@(posedge clk) disable iff (rst)
      out_valid |-> rgba[31:24] == OpaqueAlpha)
    else $error("alpha not opaque");
endmodule

// ----- tb/tb_palette_lookup_with_fade.sv -----
// testbench for the palette lookup unit with linear fade
`timescale 1ns / 1ps
module tb_palette_lookup_with_fade;
  import plf_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int DrainCycles = 40;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  kind = KIND_WR_SOURCE;
  logic [7:0]  entry_index = '0;
  logic [7:0]  red = '0;
  logic [7:0]  green = '0;
  logic [7:0]  blue = '0;
  logic [7:0]  fade_frame = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] rgba;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_RANGE_START;
  logic [7:0]  cfg_data = '0;

  palette_lookup_with_fade i_dut (.*);

  always #2 clk = ~clk;

  // shadow copy of the unit's state
  logic [23:0] src_pal [256];
  logic [23:0] tgt_pal [256];
  bit          src_written [256];
  bit          tgt_written [256];
  logic [7:0]  cur_frame;
  logic [7:0]  fade_lo, fade_hi, fade_len;
  logic [31:0] pending_colors [$];
  int          errors = 0;
  longint      cycles = 0;

  // one directed row; a nonzero want_rgba is typed in by hand
  typedef struct {
    kind_t       k;
    logic [7:0]  idx;
    logic [7:0]  r, g, b, f;
    logic [31:0] want_rgba;
  } stim_row_t;

  function automatic logic [7:0] blend(logic [7:0] s, logic [7:0] t,
                                       logic [7:0] frm, logic [7:0] steps);
    int delta;
    int part;
    delta = int'(t) - int'(s);
    part = (delta * int'(frm)) / int'(steps); // truncates toward zero
    return 8'(int'(s) + part);
  endfunction

  function automatic logic [31:0] faded_color(logic [7:0] idx);
    logic [23:0] s, t;
    logic [7:0]  frm;
    s = src_pal[idx];
    t = tgt_pal[idx];
    if (idx >= PaletteEntries) return 32'hFF000000;
    if (fade_len != 0 && idx >= fade_lo && idx <= fade_hi) begin
      frm = (cur_frame > fade_len) ? fade_len : cur_frame;
      s = {blend(s[23:16], t[23:16], frm, fade_len), blend(s[15:8], t[15:8], frm, fade_len),
           blend(s[7:0], t[7:0], frm, fade_len)};
    end
    return {OpaqueAlpha, s};
  endfunction

  // update shadow state for an accepted beat; returns 1 when a color is due
  function automatic bit apply_beat(kind_t k, logic [7:0] idx, logic [7:0] r,
                                    logic [7:0] g, logic [7:0] b, logic [7:0] f,
                                    output logic [31:0] color);
    color = '0;
    case (k)
      KIND_WR_SOURCE: begin
        src_pal[idx] = {b, g, r};
        src_written[idx] = 1'b1;
      end
      KIND_WR_TARGET: begin
        tgt_pal[idx] = {b, g, r};
        tgt_written[idx] = 1'b1;
      end
      KIND_SET_FRAME: cur_frame = f;
      default: begin
        color = faded_color(idx);
        return 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  // result checker with its own stall pattern
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pending_colors.size() == 0) begin
          $display("%0t: unexpected color beat rgba=%h", $time, rgba);
          errors++;
        end else begin
          if (rgba !== pending_colors[0]) begin
            $display("%0t: rgba mismatch expected %h actual %h", $time,
                     pending_colors[0], rgba);
            errors++;
          end
          void'(pending_colors.pop_front());
        end
      end
      // stall pattern: long clear runs, then stalls at random on 35 percent of cycles
      out_stall <= (cycles % 600 < 150) ? 1'b0 : ($urandom_range(0, 99) < 35);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic write_reg(cfg_index_t ri, logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= ri;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (ri)
      CFG_RANGE_START: fade_lo = val;
      CFG_RANGE_END:   fade_hi = val;
      CFG_FADE_STEPS:  fade_len = val;
      default: ;
    endcase
  endtask

  // drive one beat and wait for its acceptance; keep valid up if more follow
  task automatic send_beat(kind_t k, logic [7:0] idx, logic [7:0] r, logic [7:0] g,
                           logic [7:0] b, logic [7:0] f, bit hold,
                           logic [31:0] want = '0);
    logic [31:0] color;
    in_valid <= 1'b1;
    kind <= k;
    entry_index <= idx;
    red <= r;
    green <= g;
    blue <= b;
    fade_frame <= f;
    do @(posedge clk); while (in_stall);
    if (apply_beat(k, idx, r, g, b, f, color)) begin
      if (want != 0 && want !== color) begin
        $display("%0t: directed row expected %h predictor %h", $time, want, color);
        errors++;
      end
      pending_colors.push_back(color);
    end
    if (!hold) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain();
    while (pending_colors.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // pick a random written index for lookups so no unwritten entry is read
  function automatic logic [7:0] written_index();
    logic [7:0] idx;
    do idx = 8'($urandom); while (!(src_written[idx] && tgt_written[idx]));
    return idx;
  endfunction

  task automatic random_phase(int count);
    int left;
    int burst;
    int roll;
    logic [7:0] idx;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      for (int j = 0; j < burst && left > 0; j++) begin
        roll = $urandom_range(0, 99);
        idx = 8'($urandom);
        if (roll < 12)
          send_beat(KIND_WR_SOURCE, idx, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                    1'b1);
        else if (roll < 24)
          send_beat(KIND_WR_TARGET, idx, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                    1'b1);
        else if (roll < 34)
          send_beat(KIND_SET_FRAME, idx, 8'($urandom), 8'($urandom), 8'($urandom),
                    ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, fade_len)),
                    1'b1);
        else
          send_beat(KIND_LOOKUP, written_index(), 8'($urandom), 8'($urandom), 8'($urandom),
                    8'($urandom), 1'b1);
        left--;
      end
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
  endtask

  // directed rows: extremes, every kind, saturation
  stim_row_t dir_rows[] = '{
    '{KIND_WR_SOURCE, 8'd0,   8'h00, 8'h00, 8'h00, 8'h00, 32'h0},
    '{KIND_WR_TARGET, 8'd0,   8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'h0},
    '{KIND_LOOKUP,    8'd0,   8'h00, 8'h00, 8'h00, 8'h00, 32'hFF000000},
    '{KIND_WR_SOURCE, 8'd255, 8'hFF, 8'h80, 8'h01, 8'h00, 32'h0},
    '{KIND_WR_TARGET, 8'd255, 8'h00, 8'h7F, 8'hFE, 8'h00, 32'h0},
    '{KIND_LOOKUP,    8'd255, 8'h00, 8'h00, 8'h00, 8'h00, 32'hFF0180FF},
    '{KIND_SET_FRAME, 8'd0,   8'h00, 8'h00, 8'h00, 8'd30, 32'h0},
    '{KIND_LOOKUP,    8'd0,   8'h00, 8'h00, 8'h00, 8'h00, 32'hFFFFFFFF},
    '{KIND_LOOKUP,    8'd255, 8'h00, 8'h00, 8'h00, 8'h00, 32'hFFFE7F00},
    '{KIND_SET_FRAME, 8'd0,   8'h00, 8'h00, 8'h00, 8'd255, 32'h0},
    '{KIND_LOOKUP,    8'd0,   8'h00, 8'h00, 8'h00, 8'h00, 32'hFFFFFFFF},
    '{KIND_SET_FRAME, 8'd0,   8'h00, 8'h00, 8'h00, 8'd15, 32'h0},
    '{KIND_LOOKUP,    8'd0,   8'h00, 8'h00, 8'h00, 8'h00, 32'h0},
    '{KIND_LOOKUP,    8'd255, 8'h00, 8'h00, 8'h00, 8'h00, 32'h0}
  };

  initial begin
    for (int i = 0; i < 256; i++) begin
      src_pal[i] = '0;
      tgt_pal[i] = '0;
    end
    cur_frame = '0;
    fade_lo = RangeStartReset;
    fade_hi = RangeEndReset;
    fade_len = FadeStepsReset;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i])
      send_beat(dir_rows[i].k, dir_rows[i].idx, dir_rows[i].r, dir_rows[i].g, dir_rows[i].b,
                dir_rows[i].f, i != dir_rows.size() - 1, dir_rows[i].want_rgba);
    // fill both palettes so random lookups may hit any entry
    for (int i = 0; i < 256; i++) begin
      send_beat(KIND_WR_SOURCE, 8'(i), 8'($urandom), 8'($urandom), 8'($urandom), 8'h00, 1'b1);
      send_beat(KIND_WR_TARGET, 8'(i), 8'($urandom), 8'($urandom), 8'($urandom), 8'h00, 1'b1);
    end
    in_valid <= 1'b0;
    drain();

    // empty range, a write to the unused register and zero steps, then random beats
    write_reg(CFG_RANGE_START, 8'd200);
    write_reg(CFG_RANGE_END, 8'd10);
    write_reg(CFG_UNUSED, 8'hA5);
    send_beat(KIND_LOOKUP, 8'd100, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    drain();
    write_reg(CFG_RANGE_START, 8'd0);
    write_reg(CFG_RANGE_END, 8'd255);
    write_reg(CFG_FADE_STEPS, 8'd0);
    send_beat(KIND_LOOKUP, 8'd17, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    random_phase(150);
    drain();

    // several settings with random content, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(CFG_FADE_STEPS, 8'd255); end
        1: begin write_reg(CFG_FADE_STEPS, 8'd1); end
        2: begin
          write_reg(CFG_RANGE_START, 8'd64);
          write_reg(CFG_RANGE_END, 8'd191);
          write_reg(CFG_FADE_STEPS, 8'd7);
        end
        3: begin
          write_reg(CFG_RANGE_START, 8'd255);
          write_reg(CFG_RANGE_END, 8'd255);
          write_reg(CFG_FADE_STEPS, 8'd128);
        end
        default: begin
          write_reg(CFG_RANGE_START, 8'($urandom));
          write_reg(CFG_RANGE_END, 8'($urandom));
          write_reg(CFG_FADE_STEPS, 8'($urandom_range(1, 255)));
        end
      endcase
      random_phase(210);
      // hold off until every color is back
      drain();
    end

    drain();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

// ----- palette_lookup_with_fade.f -----
rtl/core/plf_pkg.sv
rtl/core/plf_ram.sv
rtl/core/plf_blend.sv
rtl/core/plf_seq.sv
rtl/core/palette_lookup_with_fade.sv
tb/tb_palette_lookup_with_fade.sv
